@@ rtl/scd_pkg.sv @@
package scd_pkg;

	// Number of stripes with a stored hash
	localparam int STRIPES = 128;

	// Width of a stripe number as it arrives on the stream
	localparam int STRIPE_W = 7;

	// Index width of the hash store
	localparam int IDX_W = (STRIPES > 1) ? $clog2(STRIPES) : 1;

	// Width that holds both a stripe number and a store index
	localparam int WIDE_W = (IDX_W > STRIPE_W) ? IDX_W : STRIPE_W;

	// Depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	// One unit of work for the back part: a finished stripe or a clear
	typedef struct packed {
		logic                clear;
		logic [STRIPE_W-1:0] stripe;
		logic [31:0]         hash;
	} job_t;

	function automatic logic [IDX_W-1:0] to_idx(input logic [STRIPE_W-1:0] s);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(s);
		return w[IDX_W-1:0];
	endfunction

	function automatic logic in_range(input logic [STRIPE_W-1:0] s);
		return (32'(s) < 32'(STRIPES));
	endfunction

endpackage

@@ rtl/scd_front.sv @@
module scd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,   // [6:0] stripe, [14:7] data_byte, [15] zero
	input  logic               s_tuser,   // [0] operation
	input  logic               s_tlast,
	input  logic               q_full,
	output logic               q_push,
	output scd_pkg::job_t      q_job
);

	logic [31:0] hash_q;
	logic [31:0] hash_next;
	logic        accept;
	logic        is_clear;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_clear = (scd_pkg::op_t'(s_tuser) == scd_pkg::OP_CLEAR);

	// One FNV-1a round per byte
	assign hash_next = (hash_q ^ {24'd0, s_tdata[14:7]}) * scd_pkg::FNV_PRIME;

	assign q_push       = accept && (is_clear || s_tlast);
	assign q_job.clear  = is_clear;
	assign q_job.stripe = s_tdata[6:0];
	assign q_job.hash   = hash_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= scd_pkg::FNV_BASIS;
		end else if (accept) begin
			if (is_clear || s_tlast) begin
				hash_q <= scd_pkg::FNV_BASIS;
			end else begin
				hash_q <= hash_next;
			end
		end
	end

endmodule

@@ rtl/scd_queue.sv @@
module scd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  scd_pkg::job_t push_job,
	output logic          full,
	output logic          avail,
	output scd_pkg::job_t head,
	input  logic          pop
);

	scd_pkg::job_t                 slots_q [scd_pkg::QUEUE_DEPTH];
	logic [scd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [scd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [scd_pkg::QCNT_W-1:0]    count_q;

	assign full  = (count_q == scd_pkg::QCNT_W'(scd_pkg::QUEUE_DEPTH));
	assign avail = (count_q != '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail)
		else $error("job popped from an empty queue");

endmodule

@@ rtl/scd_back.sv @@
module scd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_avail,
	input  scd_pkg::job_t job,
	output logic          job_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [39:0]   m_tdata     // [6:0] stripe_out, [7] changed, [39:8] hash_value
);

	logic [31:0]                 store_mem [scd_pkg::STRIPES];
	logic [scd_pkg::STRIPES-1:0] valid_q;

	logic                        v_s1;
	scd_pkg::job_t               job_s1;
	logic [31:0]                 rd_s1;
	logic                        fwd_s1;
	logic [31:0]                 fwd_hash_s1;

	logic                        m_tvalid_q;
	logic [39:0]                 m_tdata_q;

	logic [scd_pkg::IDX_W-1:0]   widx;
	logic [scd_pkg::IDX_W-1:0]   ridx;
	logic [31:0]                 stored;
	logic                        hit;
	logic                        chg;
	logic                        out_free;
	logic                        commit;
	logic                        wr_en;

	assign widx   = scd_pkg::to_idx(job_s1.stripe);
	assign ridx   = scd_pkg::to_idx(job.stripe);
	assign hit    = scd_pkg::in_range(job_s1.stripe);
	// A cleared entry reads as zero; a write to it while this job was read bypasses the read
	assign stored = !valid_q[widx] ? 32'd0 : (fwd_s1 ? fwd_hash_s1 : rd_s1);
	assign chg    = !hit || (job_s1.hash != stored);

	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = v_s1 && (job_s1.clear || out_free);
	assign wr_en    = commit && !job_s1.clear && hit && chg;
	assign job_pop  = job_avail && (!v_s1 || commit);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[widx] <= job_s1.hash;
		end
		if (job_pop) begin
			rd_s1 <= store_mem[ridx];
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_s1      <= job;
			fwd_hash_s1 <= job_s1.hash;
		end
		if (commit && !job_s1.clear) begin
			m_tdata_q <= {job_s1.hash, chg, job_s1.stripe};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			fwd_s1     <= 1'b0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				v_s1   <= 1'b1;
				fwd_s1 <= wr_en && (widx == ridx);
			end else if (commit) begin
				v_s1 <= 1'b0;
			end
			if (commit && job_s1.clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[widx] <= 1'b1;
			end
			if (commit && !job_s1.clear) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && job_s1.clear) |=> (valid_q == '0))
		else $error("stored hashes still valid after a clear");

	a_fwd_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(job_pop && !(wr_en && (widx == ridx))) |=> !fwd_s1)
		else $error("bypass set without a write to the same stripe");

endmodule

@@ rtl/stripe_change_detector.sv @@
// Throughput: one byte per cycle while the job queue is not full, set by the FNV-1a multiply
//   in the front's running-hash loop; the back, unless m_tready stalls it, retires one finished
//   stripe per cycle through its single hash store read port.
// Reset: arst_n clears the running hash to the offset basis and marks every stored hash
//   as zero at once through per-stripe valid flops; no sweep follows, items are taken at once.
module stripe_change_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [6:0] stripe, [14:7] data_byte, [15] zero
	input  logic        s_tuser,   // [0] operation: 0 data byte, 1 clear all stored hashes
	input  logic        s_tlast,   // last byte of the stripe
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [6:0] stripe_out, [7] changed, [39:8] hash_value
);

	// Front to queue
	logic          q_full;
	logic          q_push;
	scd_pkg::job_t q_job;

	// Queue to back
	logic          job_avail;
	logic          job_pop;
	scd_pkg::job_t job_head;

	// Front: fold each accepted byte into the running hash, emit a job on a
	// last byte or a clear transaction
	scd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	// Queue: hold jobs in order so front and back stall independently
	scd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.avail    (job_avail),
		.head     (job_head),
		.pop      (job_pop)
	);

	// Back: compare with the stored hash, update it, register the result; clears empty the store
	scd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (job_avail),
		.job       (job_head),
		.job_pop   (job_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

@@ sim/stripe_change_detector_tb.sv @@
module stripe_change_detector_tb;

	localparam int ITEMS   = 950;
	localparam int LANES   = 6;    // stripes in one working frame
	localparam int MAX_LEN = 16;   // longest stripe in bytes

	typedef struct packed {
		logic [6:0]  stripe;
		logic        changed;
		logic [31:0] hash;
	} stripe_report_t;

	// Directed stimulus; pin marks rows whose report is typed in here
	typedef struct packed {
		scd_pkg::op_t op;
		logic [6:0]   stripe;
		logic [7:0]   data;
		logic         last;
		logic         pin;
		logic         pin_chg;
		logic [31:0]  pin_hash;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	// Predictor state
	logic [31:0] hash_acc;
	logic [31:0] hash_store [scd_pkg::STRIPES];

	stripe_report_t due_reports [$];
	stim_row_t      directed [$];
	logic [15:0]    reach [logic [31:0]];   // hash after two bytes -> those bytes

	logic [6:0] lane_id [LANES];
	logic [7:0] lane_bytes [LANES][MAX_LEN];
	int         lane_len [LANES];

	int fail_count = 0;
	int sent = 0;
	bit calm = 1'b0;

	stripe_change_detector DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		fail_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Fold one transaction into the running hash; return the stripe report it closes
	function automatic void track_stripe_hash(input scd_pkg::op_t op, input logic [6:0] stripe,
			input logic [7:0] data, input logic last,
			output bit has_rep, output stripe_report_t rep);
		logic [31:0] h;
		has_rep = 1'b0;
		rep = '0;
		if (op == scd_pkg::OP_CLEAR) begin
			foreach (hash_store[i])
				hash_store[i] = '0;
			hash_acc = scd_pkg::FNV_BASIS;
			return;
		end
		h = (hash_acc ^ {24'd0, data}) * scd_pkg::FNV_PRIME;
		if (!last) begin
			hash_acc = h;
			return;
		end
		rep.stripe = stripe;
		rep.hash = h;
		if (int'(stripe) < scd_pkg::STRIPES) begin
			rep.changed = (h != hash_store[stripe]);
			if (rep.changed)
				hash_store[stripe] = h;
		end else begin
			rep.changed = 1'b1;
		end
		hash_acc = scd_pkg::FNV_BASIS;
		has_rep = 1'b1;
	endfunction

	// Enter and leave at a falling edge; hold the transaction until it is taken
	task automatic send_item(input scd_pkg::op_t op, input logic [6:0] stripe,
			input logic [7:0] data, input logic last, input logic pin, input logic pin_chg,
			input logic [31:0] pin_hash);
		bit             has_rep;
		stripe_report_t rep;
		if (!calm && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, data, stripe};
		s_tuser <= op;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		track_stripe_hash(op, stripe, data, last, has_rep, rep);
		if (has_rep) begin
			if (pin) begin
				rep.changed = pin_chg;
				rep.hash = pin_hash;
			end
			due_reports.push_back(rep);
		end
		sent++;
		@(negedge clk);
	endtask

	// Result side: stall in random bursts, none once the run turns calm
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else if (!calm && $urandom_range(0, 7) == 0)
				hold = $urandom_range(1, 15);
			m_tready <= (hold == 0);
		end
	end

	always @(posedge clk) begin
		stripe_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_reports.size() == 0) begin
				flag_mismatch($sformatf("report %h with none expected", m_tdata));
			end else begin
				want = due_reports.pop_front();
				if (m_tdata[6:0] !== want.stripe)
					flag_mismatch($sformatf("stripe_out %0d, want %0d", m_tdata[6:0], want.stripe));
				if (m_tdata[7] !== want.changed)
					flag_mismatch($sformatf("stripe %0d changed %b, want %b",
						want.stripe, m_tdata[7], want.changed));
				if (m_tdata[39:8] !== want.hash)
					flag_mismatch($sformatf("stripe %0d hash %h, want %h",
						want.stripe, m_tdata[39:8], want.hash));
			end
		end
	end

	initial begin
		logic [31:0] inv;
		logic [31:0] h1;
		logic [31:0] hf;
		logic [39:0] zero_seq;
		bit          found;
		int          x1, x2, zl, zm, zf;
		int          round, mode, cut;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = scd_pkg::OP_DATA;
		s_tlast = 1'b0;
		hash_acc = scd_pkg::FNV_BASIS;
		foreach (hash_store[i])
			hash_store[i] = '0;
		foreach (lane_id[i])
			lane_id[i] = 7'd0;

		// Find five bytes that hash to zero: meet in the middle, walking back from
		// a zero hash with the inverse of the prime (Newton steps mod 2^32)
		inv = scd_pkg::FNV_PRIME;
		repeat (5) inv = inv * (32'd2 - scd_pkg::FNV_PRIME * inv);
		for (x1 = 0; x1 < 256; x1++) begin
			h1 = (scd_pkg::FNV_BASIS ^ x1) * scd_pkg::FNV_PRIME;
			for (x2 = 0; x2 < 256; x2++)
				reach[(h1 ^ x2) * scd_pkg::FNV_PRIME] = {x1[7:0], x2[7:0]};
		end
		found = 1'b0;
		zero_seq = '0;
		for (zl = 0; zl < 256 && !found; zl++)
			for (zm = 0; zm < 256 && !found; zm++)
				for (zf = 0; zf < 16 && !found; zf++) begin
					hf = ((((zl * inv) ^ zm) * inv) ^ zf);
					if (reach.exists(hf)) begin
						found = 1'b1;
						zero_seq = {reach[hf], zf[7:0], zm[7:0], zl[7:0]};
					end
				end
		reach.delete();

		// "a" and "foobar" have well-known FNV-1a hashes
		directed.push_back('{scd_pkg::OP_DATA, 7'd0, 8'h61, 1'b1, 1'b1, 1'b1, 32'he40c292c});
		directed.push_back('{scd_pkg::OP_DATA, 7'd0, 8'h61, 1'b1, 1'b1, 1'b0, 32'he40c292c});
		directed.push_back('{scd_pkg::OP_DATA, 7'h2a, 8'h66, 1'b0, 1'b0, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_DATA, 7'h55, 8'h6f, 1'b0, 1'b0, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_DATA, 7'h00, 8'h6f, 1'b0, 1'b0, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_DATA, 7'h7f, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_DATA, 7'h13, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_DATA, 7'd127, 8'h72, 1'b1, 1'b1, 1'b1, 32'hbf9cf968});
		directed.push_back('{scd_pkg::OP_DATA, 7'd127, 8'hff, 1'b1, 1'b0, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_DATA, 7'd64, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0});
		// Partial stripe, then a clear with every other field set: drop the partial hash
		directed.push_back('{scd_pkg::OP_DATA, 7'd3, 8'haa, 1'b0, 1'b0, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_CLEAR, 7'd127, 8'hff, 1'b1, 1'b0, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_DATA, 7'd0, 8'h61, 1'b1, 1'b1, 1'b1, 32'he40c292c});
		directed.push_back('{scd_pkg::OP_CLEAR, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0});
		// A zero hash matches a cleared entry; once a real hash is stored it differs
		if (found)
			for (int k = 0; k < 5; k++)
				directed.push_back('{scd_pkg::OP_DATA, 7'd5, zero_seq[39-8*k -: 8], k == 4,
					k == 4, 1'b0, 32'd0});
		directed.push_back('{scd_pkg::OP_DATA, 7'd5, 8'h61, 1'b1, 1'b1, 1'b1, 32'he40c292c});
		if (found)
			for (int k = 0; k < 5; k++)
				directed.push_back('{scd_pkg::OP_DATA, 7'd5, zero_seq[39-8*k -: 8], k == 4,
					k == 4, 1'b1, 32'd0});

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[r])
			send_item(directed[r].op, directed[r].stripe, directed[r].data, directed[r].last,
				directed[r].pin, directed[r].pin_chg, directed[r].pin_hash);

		// Frames of a few stripes, resent with occasional edits so that both
		// changed and unchanged reports occur; mix in clears and broken stripes
		round = 0;
		while (sent < ITEMS) begin
			if (round % 5 == 0)
				for (int l = 0; l < LANES; l++) begin
					case ($urandom_range(0, 5))
						0: lane_id[l] = 7'd0;
						1: lane_id[l] = 7'd127;
						2: lane_id[l] = lane_id[0];
						default: lane_id[l] = 7'($urandom_range(0, 127));
					endcase
					lane_len[l] = ($urandom_range(0, 7) == 0) ? MAX_LEN : $urandom_range(1, 8);
					for (int b = 0; b < MAX_LEN; b++)
						lane_bytes[l][b] = 8'($urandom);
				end
			for (int l = 0; l < LANES; l++) begin
				if ($urandom_range(0, 3) == 0)
					lane_bytes[l][$urandom_range(0, lane_len[l] - 1)] = 8'($urandom);
				mode = $urandom_range(0, 24);
				if (mode == 0)
					send_item(scd_pkg::OP_CLEAR, 7'($urandom), 8'($urandom), 1'($urandom),
						1'b0, 1'b0, 32'd0);
				if (mode == 2)
					send_item(scd_pkg::OP_DATA, 7'($urandom), 8'($urandom), 1'b1,
						1'b0, 1'b0, 32'd0);
				cut = (mode == 1) ? $urandom_range(0, lane_len[l] - 1) : lane_len[l];
				for (int b = 0; b < cut; b++)
					send_item(scd_pkg::OP_DATA,
						(b == lane_len[l] - 1) ? lane_id[l] : 7'($urandom),
						lane_bytes[l][b], b == lane_len[l] - 1, 1'b0, 1'b0, 32'd0);
				if (mode == 1)
					send_item(scd_pkg::OP_CLEAR, 7'($urandom), 8'($urandom), 1'($urandom),
						1'b0, 1'b0, 32'd0);
			end
			if (sent >= ITEMS - 100)
				calm = 1'b1;
			round++;
		end
		s_tvalid <= 1'b0;

		// Drain, then allow for the result path before the verdict
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/scd_pkg.sv
rtl/scd_front.sv
rtl/scd_queue.sv
rtl/scd_back.sv
rtl/stripe_change_detector.sv
sim/stripe_change_detector_tb.sv
